/* hw/rtl/gdspw_pkg.sv */
package gdspw_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic [2:0] start_page;
		logic [6:0] start_column;
	} gdspw_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} gdspw_rsp_t;

	localparam int unsigned GLYPH_COLS  = 8;
	localparam int unsigned GLYPH_COUNT = 12;
	localparam int unsigned ROM_DEPTH   = GLYPH_COLS * GLYPH_COUNT;
	localparam int unsigned ROM_AW      = $clog2(ROM_DEPTH);

	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [2:0] MAX_PAGE   = 3'd6;

	// Beat numbering within one page: three commands, then sixteen data beats.
	localparam logic [4:0] BEAT_PAGE   = 5'd0;
	localparam logic [4:0] BEAT_COL_LO = 5'd1;
	localparam logic [4:0] BEAT_COL_HI = 5'd2;
	localparam logic [4:0] BEAT_DATA0  = 5'd3;
	localparam logic [4:0] BEAT_END    = 5'd18;

	localparam logic [3:0] IDX_COLON = 4'd10;
	localparam logic [3:0] IDX_DASH  = 4'd11;

	localparam logic [7:0] FONT_ROM [0:ROM_DEPTH-1] = '{
		8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00, 8'h00, 8'h00,
		8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 8'h00, 8'h00, 8'h00,
		8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00, 8'h00, 8'h00,
		8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00, 8'h00, 8'h00,
		8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00, 8'h00, 8'h00,
		8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00,
		8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00, 8'h00,
		8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h3C, 8'h3C, 8'h00, 8'h00, 8'h00
	};

	// Each nibble bit b fills bits 2b and 2b+1.
	function automatic logic [7:0] stretch_nibble(input logic [3:0] nib);
		logic [7:0] r;
		r = '0;
		for (int b = 0; b < 4; b++) begin
			r[2*b]   = nib[b];
			r[2*b+1] = nib[b];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/glyph_double_size_page_writer.sv */
// Channel | Dir | Handshake        | Beat payload
// req     | in  | req_valid/stall  | gdspw_req_t: char_code, start_page, start_column
// rsp     | out | rsp_valid/stall  | gdspw_rsp_t: out_byte, is_data, last
//
// A drawn glyph gives 38 beats, one per cycle while rsp is not stalled, from the
// beat sequencer that walks the font ROM one column read per beat. A character
// that is not drawn is taken without making the sequencer busy and gives nothing.
// ROM reads are registered; a beat passes the ROM stage, then the output register.
// Reset clears the sequencer's busy, sel and beat registers and the valid bits only.
// A stall on rsp holds the output register; the sequencer and ROM read freeze
// once the ROM stage also holds a beat.
module glyph_double_size_page_writer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  gdspw_pkg::gdspw_req_t req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output gdspw_pkg::gdspw_rsp_t rsp
);

	localparam int unsigned ROM_ADDR_W = gdspw_pkg::ROM_AW;

	// sequencer
	logic       busy_q;
	logic [3:0] idx_q;
	logic [2:0] page_q;
	logic [6:0] col_q;
	logic       sel_q;
	logic [4:0] beat_q;

	// stage 1: ROM read in flight
	logic       valid_s1;
	logic       data_s1;
	logic       hi_s1;
	logic       last_s1;
	logic [7:0] cmd_s1;
	logic [7:0] rom_s1;

	// output register
	logic                  rsp_valid_q;
	gdspw_pkg::gdspw_rsp_t rsp_q;

	logic       out_free;
	logic       s1_adv;
	logic       issue;
	logic       last_beat;
	logic       req_acc;
	logic       char_ok;
	logic [3:0] char_idx;
	logic [4:0] data_beat;
	logic [ROM_ADDR_W-1:0] rom_addr;
	logic [7:0] cmd_byte;

	always_comb begin
		char_ok  = 1'b1;
		char_idx = '0;
		if (req.char_code == 8'h3A) begin
			char_idx = gdspw_pkg::IDX_COLON;
		end else if (req.char_code == 8'h2F) begin
			char_idx = gdspw_pkg::IDX_DASH;
		end else if (req.char_code >= 8'h30 && req.char_code <= 8'h39) begin
			char_idx = 4'(req.char_code - 8'h30);
		end else begin
			char_ok = 1'b0;
		end
	end

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign s1_adv    = !valid_s1 || out_free;
	assign issue     = busy_q && s1_adv;
	assign last_beat = sel_q && (beat_q == gdspw_pkg::BEAT_END);
	assign req_stall = busy_q && !(issue && last_beat);
	assign req_acc   = req_valid && !req_stall;

	assign data_beat = beat_q - gdspw_pkg::BEAT_DATA0;
	assign rom_addr  = {idx_q, data_beat[3:1]};

	always_comb begin
		case (beat_q)
			gdspw_pkg::BEAT_PAGE:   cmd_byte = gdspw_pkg::CMD_PAGE + {5'd0, page_q} + {7'd0, sel_q};
			gdspw_pkg::BEAT_COL_LO: cmd_byte = gdspw_pkg::CMD_COL_LO + {4'd0, col_q[3:0]};
			gdspw_pkg::BEAT_COL_HI: cmd_byte = gdspw_pkg::CMD_COL_HI + {5'd0, col_q[6:4]};
			default:                cmd_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= 1'b0;
			beat_q <= '0;
		end else if (req_acc) begin
			busy_q <= char_ok;
			sel_q  <= 1'b0;
			beat_q <= '0;
		end else if (issue) begin
			if (beat_q == gdspw_pkg::BEAT_END) begin
				// end of a page: after the upper page advance to the lower page; after the lower page drop busy
				beat_q <= '0;
				sel_q  <= 1'b1;
				if (sel_q) begin
					busy_q <= 1'b0;
				end
			end else begin
				beat_q <= beat_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			idx_q  <= char_idx;
			page_q <= (req.start_page > gdspw_pkg::MAX_PAGE) ? gdspw_pkg::MAX_PAGE
				: req.start_page;
			col_q  <= req.start_column;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= issue;
		end
	end

	// font ROM: synchronous read, held while the pipeline is frozen
	always_ff @(posedge clk) begin
		if (issue) begin
			rom_s1  <= gdspw_pkg::FONT_ROM[rom_addr];
			data_s1 <= (beat_q >= gdspw_pkg::BEAT_DATA0);
			hi_s1   <= sel_q;
			last_s1 <= last_beat;
			cmd_s1  <= cmd_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rsp_q.is_data  <= data_s1;
			rsp_q.last     <= last_s1;
			rsp_q.out_byte <= data_s1
				? gdspw_pkg::stretch_nibble(hi_s1 ? rom_s1[7:4] : rom_s1[3:0])
				: cmd_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sim/glyph_beat_checker.sv */
module glyph_beat_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  gdspw_pkg::gdspw_req_t req,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  gdspw_pkg::gdspw_rsp_t rsp,
	output int unsigned           mismatches,
	output int unsigned           pending,
	output int unsigned           glyphs_drawn,
	output int unsigned           chars_skipped,
	output int unsigned           beats_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] OP_PAGE     = 8'hB0;
	localparam logic [7:0] OP_COL_LO   = 8'h00;
	localparam logic [7:0] OP_COL_HI   = 8'h10;
	localparam logic [2:0] TOP_PAGE    = 3'd6;
	localparam logic [3:0] SLOT_COLON  = 4'd10;
	localparam logic [3:0] SLOT_DASH   = 4'd11;
	localparam int         REPORT_MAX  = 10;

	// One 64-bit row per glyph, leftmost font column in the top byte.
	localparam logic [0:11][63:0] FONT_ROWS = {
		64'h3E51_4945_3E00_0000,
		64'h0042_7F40_0000_0000,
		64'h4261_5149_4600_0000,
		64'h2141_454B_3100_0000,
		64'h1814_127F_1000_0000,
		64'h2745_4545_3900_0000,
		64'h3C4A_4949_3000_0000,
		64'h0171_0905_0300_0000,
		64'h3649_4949_3600_0000,
		64'h0649_4929_1E00_0000,
		64'h0000_1400_0000_0000,
		64'h0000_003C_3C00_0000
	};

	gdspw_pkg::gdspw_rsp_t expected_beats [$];

	initial begin
		mismatches    = 0;
		pending       = 0;
		glyphs_drawn  = 0;
		chars_skipped = 0;
		beats_checked = 0;
	end

	// Stretch each nibble bit over two display rows.
	function automatic logic [7:0] widen_rows(input logic [3:0] nib);
		logic [7:0] r;
		r = '0;
		for (int b = 3; b >= 0; b--)
			r = {r[5:0], {2{nib[b]}}};
		return r;
	endfunction

	task automatic expect_beat(input logic [7:0] value, input logic data, input logic fin);
		gdspw_pkg::gdspw_rsp_t b;
		b.out_byte = value;
		b.is_data  = data;
		b.last     = fin;
		expected_beats.push_back(b);
	endtask

	task automatic draw_glyph(input gdspw_pkg::gdspw_req_t item);
		logic [3:0]  slot;
		logic [2:0]  page;
		logic [63:0] row;
		logic [7:0]  font_col;
		logic [7:0]  tall;
		if (item.char_code == ":") begin
			slot = SLOT_COLON;
		end else if (item.char_code == "/") begin
			slot = SLOT_DASH;
		end else if (item.char_code >= "0" && item.char_code <= "9") begin
			slot = 4'(item.char_code - "0");
		end else begin
			chars_skipped++;
			return;
		end
		glyphs_drawn++;
		// Clamp so the lower half still lands on a real page.
		page = (item.start_page > TOP_PAGE) ? TOP_PAGE : item.start_page;
		row  = FONT_ROWS[slot];
		for (int half = 0; half < 2; half++) begin
			expect_beat(8'(OP_PAGE + page + half), 1'b0, 1'b0);
			expect_beat(OP_COL_LO | {4'h0, item.start_column[3:0]}, 1'b0, 1'b0);
			expect_beat(OP_COL_HI | {5'h0, item.start_column[6:4]}, 1'b0, 1'b0);
			for (int c = 0; c < 8; c++) begin
				font_col = row[63 - 8*c -: 8];
				tall = widen_rows(half == 0 ? font_col[3:0] : font_col[7:4]);
				expect_beat(tall, 1'b1, 1'b0);
				expect_beat(tall, 1'b1, (half == 1 && c == 7));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				beats_checked++;
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected beat byte %02h data %b last %b",
							$realtime, rsp.out_byte, rsp.is_data, rsp.last);
				end else begin
					if (rsp.out_byte !== expected_beats[0].out_byte ||
					    rsp.is_data  !== expected_beats[0].is_data ||
					    rsp.last     !== expected_beats[0].last) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: beat %0d expected %02h/%b/%b got %02h/%b/%b",
								$realtime, beats_checked,
								expected_beats[0].out_byte, expected_beats[0].is_data,
								expected_beats[0].last,
								rsp.out_byte, rsp.is_data, rsp.last);
					end
					void'(expected_beats.pop_front());
				end
			end
			if (req_valid && !req_stall)
				draw_glyph(req);
			pending <= expected_beats.size();
		end
	end

endmodule

/* sim/glyph_double_size_page_writer_tb.sv */
module glyph_double_size_page_writer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_GLYPHS  = 120;
	localparam int CALM_TAIL      = 25;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	gdspw_pkg::gdspw_req_t req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	gdspw_pkg::gdspw_rsp_t rsp;

	logic        quiet      = 1'b0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;

	int unsigned mismatch_count;
	int unsigned beats_pending;
	int unsigned glyphs_drawn;
	int unsigned chars_skipped;
	int unsigned beats_checked;

	always #6 clk = ~clk;

	glyph_double_size_page_writer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	glyph_beat_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.mismatches    (mismatch_count),
		.pending       (beats_pending),
		.glyphs_drawn  (glyphs_drawn),
		.chars_skipped (chars_skipped),
		.beats_checked (beats_checked)
	);

	// Receiver stalls start at random, and none start while quiet is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && !rsp_stall && $urandom_range(0, 4) == 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_char(input logic [7:0] code, input logic [2:0] page,
		input logic [6:0] col);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{char_code: code, start_page: page, start_column: col};
		do @(posedge clk); while (req_stall);
	endtask

	// Hold the sender until every predicted beat has drained.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (beats_pending != 0);
	endtask

	function automatic logic [7:0] pick_glyph_code();
		int unsigned r;
		r = $urandom_range(0, 11);
		if (r < 10)
			return 8'("0" + r);
		else if (r == 10)
			return ":";
		else
			return "/";
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every glyph, page and column extremes, clamped page, rejected codes
		send_char("0", 3'd0, 7'h00);
		send_char("1", 3'd6, 7'h7F);
		send_char("2", 3'd7, 7'h0F);
		send_char("3", 3'd3, 7'h10);
		send_char(8'h00, 3'd0, 7'h00);
		send_char("4", 3'd5, 7'h55);
		send_char("5", 3'd1, 7'h2A);
		send_char(8'hFF, 3'd7, 7'h7F);
		send_char("6", 3'd2, 7'h70);
		send_char("7", 3'd4, 7'h3C);
		send_char(".", 3'd2, 7'h11);
		send_char("8", 3'd7, 7'h7F);
		send_char("9", 3'd0, 7'h40);
		send_char(";", 3'd5, 7'h05);
		send_char(":", 3'd6, 7'h01);
		send_char("A", 3'd1, 7'h20);
		send_char("/", 3'd2, 7'h6E);
		send_char(8'h80, 3'd3, 7'h33);
		wait_drained();

		for (int n = 0; n < RANDOM_GLYPHS; n++) begin
			if (n >= RANDOM_GLYPHS - CALM_TAIL)
				quiet <= 1'b1;
			else if (n % 20 == 0)
				quiet <= ($urandom_range(0, 3) == 0);
			if (n == RANDOM_GLYPHS / 2)
				wait_drained();
			if ($urandom_range(0, 3) == 0)
				send_char(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
					7'($urandom_range(0, 127)));
			send_char(pick_glyph_code(), 3'($urandom_range(0, 7)),
				7'($urandom_range(0, 127)));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d characters: %0d drawn, %0d rejected without output.",
			glyphs_drawn + chars_skipped, glyphs_drawn, chars_skipped);
		$display("%0d display beats checked with random stalls on both channels.",
			beats_checked);
		if (mismatch_count == 0 && beats_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
